FILE: hdl/wmp_pkg.sv
// Shared widths, types and constants for the weighted motion predictor.
package wmp_pkg;

  localparam int COORD_BITS  = 12;
  localparam int CENTER_BITS = COORD_BITS + 1;
  localparam int PRED_BITS   = 15;
  localparam int COUNT_BITS  = 3;
  localparam int DEPTH       = 5;

  // Weighted move sum: at most four times a center, plus sign.
  localparam int SUM_BITS    = COORD_BITS + 4;
  // Doubled magnitude plus denominator.
  localparam int DIV_BITS    = SUM_BITS + 1;
  // Reciprocal scale, wide enough that the ceiling error never changes a floor.
  localparam int RECIP_SHIFT = DIV_BITS + 1;
  localparam int RECIP3      = ((2 ** RECIP_SHIFT) + 2) / 3;
  localparam int RECIP5      = ((2 ** RECIP_SHIFT) + 4) / 5;

  // Sum of weights for three, four and five held centers.
  localparam int DEN3        = 3;
  localparam int DEN4        = 6;
  localparam int DEN5        = 10;

  localparam logic CMD_APPEND = 1'b1;

  typedef logic [COORD_BITS-1:0]         coord_t;
  typedef logic [CENTER_BITS-1:0]        center_t;
  typedef logic signed [SUM_BITS-1:0]    sum_t;
  typedef logic [COUNT_BITS-1:0]         count_t;
  typedef logic [PRED_BITS-1:0]          pred_t;

  localparam count_t DEPTH_COUNT = count_t'(DEPTH);

endpackage

FILE: hdl/wmp_round_div.sv
// Rounded weighted-mean divide and prediction add for one coordinate.
module wmp_round_div import wmp_pkg::*; (
  input  sum_t    sum,
  input  count_t  count,
  input  center_t last,
  output pred_t   pred
);

  localparam int PROD_BITS = DIV_BITS + RECIP_SHIFT;
  localparam int WIDE_BITS = SUM_BITS + PRED_BITS;

  logic [SUM_BITS-1:0]           mag;
  logic [DIV_BITS-1:0]           den;
  logic [DIV_BITS-1:0]           dividend;
  logic [DIV_BITS-1:0]           scaled;
  logic [RECIP_SHIFT-1:0]        recip;
  logic [PROD_BITS-1:0]          prod;
  logic [SUM_BITS-1:0]           quot;
  logic signed [WIDE_BITS-1:0]   step;
  logic signed [WIDE_BITS-1:0]   pred_wide;

  always_comb begin
    mag = sum[SUM_BITS-1] ? $unsigned(-sum) : $unsigned(sum);

    case (count)
      count_t'(3): begin
        den   = DIV_BITS'(DEN3);
        recip = RECIP_SHIFT'(RECIP3);
      end
      count_t'(4): begin
        den   = DIV_BITS'(DEN4);
        recip = RECIP_SHIFT'(RECIP3);
      end
      count_t'(5): begin
        den   = DIV_BITS'(DEN5);
        recip = RECIP_SHIFT'(RECIP5);
      end
      default: begin
        den   = '0;
        recip = RECIP_SHIFT'(RECIP3);
      end
    endcase

    // floor((2|s| + d) / 2d): pre-shift folds the factor of two or four out of 2d
    dividend = {mag, 1'b0} + den;
    scaled   = (count == count_t'(3)) ? (dividend >> 1) : (dividend >> 2);
    prod     = PROD_BITS'(scaled) * PROD_BITS'(recip);

    case (count)
      count_t'(0): quot = '0;
      count_t'(1): quot = '0;
      count_t'(2): quot = mag;
      default:     quot = prod[RECIP_SHIFT +: SUM_BITS];
    endcase

    step      = $signed({{PRED_BITS{1'b0}}, quot});
    step      = sum[SUM_BITS-1] ? -step : step;
    pred_wide = $signed(WIDE_BITS'(last)) + step;
    pred      = pred_wide[PRED_BITS-1:0];
  end

endmodule

FILE: hdl/weighted_motion_predictor.sv
// Top level of the weighted motion predictor: input, history and result stages.
//
// Input channel (in_valid/in_stall): a command (start or append) and a
// bounding rectangle. Output channel (out_valid/out_stall): the rectangle's
// center, the predicted next center and the number of centers used.
// Every input transaction yields exactly one output transaction, in order.
//
// Each transaction passes through the input register, the history/sum register
// and the result register, in that order.
// Throughput: one transaction per cycle while out_stall is low; each stage loads
// whenever it is empty or the stage after it moves on, so a stalled result only
// holds the stages behind it once they are full.
//
// Track history (five centers per axis) updates when a transaction leaves
// the input register; the weighted sum is formed there, and the rounded
// divide by 1, 3, 6 or 10 is a constant reciprocal multiply in the last stage.
//
// Reset (rst, synchronous) empties all stages and clears the held count, so
// the first transaction after reset always starts a new track. While
// out_stall is high, the result holds and in_stall rises once the pipe fills.
module weighted_motion_predictor import wmp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  input  logic    command,
  input  coord_t  rect_x,
  input  coord_t  rect_y,
  input  coord_t  rect_width,
  input  coord_t  rect_height,
  output logic    out_valid,
  input  logic    out_stall,
  output center_t center_x,
  output center_t center_y,
  output pred_t   predicted_x,
  output pred_t   predicted_y,
  output count_t  history_count
);

  // Input register
  logic    s1_valid;
  logic    s1_command;
  coord_t  s1_rect_x;
  coord_t  s1_rect_y;
  coord_t  s1_rect_width;
  coord_t  s1_rect_height;

  // Sum register
  logic    s2_valid;
  center_t s2_center_x;
  center_t s2_center_y;
  sum_t    s2_sum_x;
  sum_t    s2_sum_y;
  count_t  s2_count;

  // Track state
  center_t hist_x [DEPTH];
  center_t hist_y [DEPTH];
  count_t  held_count;

  center_t hist_x_next [DEPTH];
  center_t hist_y_next [DEPTH];
  count_t  held_count_next;
  count_t  base;
  center_t cx;
  center_t cy;
  sum_t    sum_x;
  sum_t    sum_y;
  pred_t   pred_x;
  pred_t   pred_y;

  logic    s1_ready;
  logic    s2_ready;
  logic    out_ready;

  // (n-1)*newest minus the older centers equals the sum of k*move_k.
  function automatic sum_t weighted_sum(input center_t h [DEPTH], input count_t n);
    sum_t   acc;
    count_t older;
    older = n - 1'b1;
    acc   = sum_t'(older) * $signed({1'b0, h[DEPTH-1]});
    for (int k = 0; k < DEPTH - 1; k++) begin
      if (count_t'(k) < older) begin
        acc = acc - $signed({1'b0, h[k]});
      end
    end
    return acc;
  endfunction

  assign out_ready = !out_valid || !out_stall;
  assign s2_ready  = !s2_valid || out_ready;
  assign s1_ready  = !s1_valid || s2_ready;
  assign in_stall  = !s1_ready;

  always_comb begin
    cx = CENTER_BITS'(s1_rect_x) + CENTER_BITS'(s1_rect_width >> 1);
    cy = CENTER_BITS'(s1_rect_y) + CENTER_BITS'(s1_rect_height >> 1);

    // Start over on a start command or an empty or invalid history
    base = (s1_command == CMD_APPEND && held_count != '0 && held_count <= DEPTH_COUNT)
           ? held_count : '0;

    for (int i = 0; i < DEPTH - 1; i++) begin
      if (base == DEPTH_COUNT) begin
        hist_x_next[i] = hist_x[i+1];
        hist_y_next[i] = hist_y[i+1];
      end else if (count_t'(i) == base) begin
        hist_x_next[i] = cx;
        hist_y_next[i] = cy;
      end else begin
        hist_x_next[i] = hist_x[i];
        hist_y_next[i] = hist_y[i];
      end
    end
    if (base == DEPTH_COUNT || base == DEPTH_COUNT - 1'b1) begin
      hist_x_next[DEPTH-1] = cx;
      hist_y_next[DEPTH-1] = cy;
    end else begin
      hist_x_next[DEPTH-1] = hist_x[DEPTH-1];
      hist_y_next[DEPTH-1] = hist_y[DEPTH-1];
    end

    held_count_next = (base == DEPTH_COUNT) ? DEPTH_COUNT : base + 1'b1;
  end

  // The newest center always sits last in the weighted sum, so feed it there.
  always_comb begin
    center_t wx [DEPTH];
    center_t wy [DEPTH];
    for (int i = 0; i < DEPTH - 1; i++) begin
      wx[i] = hist_x_next[i];
      wy[i] = hist_y_next[i];
    end
    wx[DEPTH-1] = cx;
    wy[DEPTH-1] = cy;
    sum_x = weighted_sum(wx, held_count_next);
    sum_y = weighted_sum(wy, held_count_next);
  end

  wmp_round_div u_div_x (
    .sum   (s2_sum_x),
    .count (s2_count),
    .last  (s2_center_x),
    .pred  (pred_x)
  );

  wmp_round_div u_div_y (
    .sum   (s2_sum_y),
    .count (s2_count),
    .last  (s2_center_y),
    .pred  (pred_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
      out_valid  <= 1'b0;
      held_count <= '0;
    end else begin
      if (s1_ready) begin
        s1_valid <= in_valid;
      end
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
      if (out_ready) begin
        out_valid <= s2_valid;
      end
      // Advance the track only when the transaction leaves the input register
      if (s1_valid && s2_ready) begin
        held_count <= held_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && s1_ready) begin
      s1_command     <= command;
      s1_rect_x      <= rect_x;
      s1_rect_y      <= rect_y;
      s1_rect_width  <= rect_width;
      s1_rect_height <= rect_height;
    end
    if (s1_valid && s2_ready) begin
      hist_x      <= hist_x_next;
      hist_y      <= hist_y_next;
      s2_center_x <= cx;
      s2_center_y <= cy;
      s2_sum_x    <= sum_x;
      s2_sum_y    <= sum_y;
      s2_count    <= held_count_next;
    end
    if (s2_valid && out_ready) begin
      center_x      <= s2_center_x;
      center_y      <= s2_center_y;
      predicted_x   <= pred_x;
      predicted_y   <= pred_y;
      history_count <= s2_count;
    end
  end

endmodule

FILE: hdl/wmp_checker.sv
// Port-level checks for the weighted motion predictor, bound to the top level.
module wmp_checker import wmp_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    in_valid,
  input logic    in_stall,
  input logic    command,
  input coord_t  rect_x,
  input coord_t  rect_y,
  input coord_t  rect_width,
  input coord_t  rect_height,
  input logic    out_valid,
  input logic    out_stall,
  input center_t center_x,
  input center_t center_y,
  input pred_t   predicted_x,
  input pred_t   predicted_y,
  input count_t  history_count
);

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // Count of centers stays within one to five
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (history_count >= count_t'(1) && history_count <= DEPTH_COUNT))
    else $error("history_count out of range");

  // A lone center predicts itself
  a_single_center: assert property (@(posedge clk) disable iff (rst)
    (out_valid && history_count == count_t'(1)) |->
      (predicted_x == PRED_BITS'(center_x) && predicted_y == PRED_BITS'(center_y)))
    else $error("single-center prediction differs from center");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      (out_valid && $stable(center_x) && $stable(predicted_x) && $stable(history_count)))
    else $error("stalled result changed");

endmodule

bind weighted_motion_predictor wmp_checker u_wmp_checker (.*);
